[sv/sll_pkg.sv]
// Shared types and constants for the sorted linked list insert block.
package sll_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int VALUE_W      = 32;
   localparam int MODE_W       = 2;
   localparam int STATUS_W     = 2;
   localparam int REQ_TDATA_W  = 40;
   localparam int RSP_TDATA_W  = 40;

   typedef enum logic [MODE_W-1:0] {
      MODE_APPEND   = 2'd0,
      MODE_INSERT   = 2'd1,
      MODE_TRAVERSE = 2'd2,
      MODE_CLEAR    = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSERT,
      ST_LINK_NEW,
      ST_LINK_PREV,
      ST_TRAVERSE,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic value_we;
      logic link_we;
   } mem_ctl_type;

endpackage

[sv/sorted_linked_list_insert.sv]
// Top level: sorted linked list with append, sorted insert, traverse and clear.
//
// Requests arrive on req_ (mode and value); results leave on rsp_ with
// rsp_tlast set on the final result of each request. One request is worked
// on at a time; req_tready is high only while the sequencer is idle.
// Append, clear and rejected (full) requests give one result. Sorted insert
// walks the list one node per cycle through the store's read port. Traverse
// returns one value per cycle while rsp_tready lets the output register take
// it; an empty list gives one result with the empty status.
// Results go through one output register: when the receiver holds
// rsp_tready low the sequencer waits and the stores keep their read data.
// Reset empties the list at once (head, tail and count); the stores hold no
// reset value and are only read at entries already linked.
module sorted_linked_list_insert import sll_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // mode[1:0], value[33:2], zero pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // value_out[31:0], status[33:32], zero pad
   output logic                   rsp_tlast
);

   localparam int              IDX_W  = $clog2(CAPACITY + 1);
   localparam int              ADDR_W = $clog2(CAPACITY);
   localparam logic [IDX_W-1:0] END   = IDX_W'(CAPACITY);

   state_type          state_ff, state_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   status_type         status_ff, status_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [IDX_W-1:0]   tail_ff, tail_in;
   logic [IDX_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   cur_ff, cur_in;
   logic [IDX_W-1:0]   prev_ff, prev_in;
   logic [IDX_W-1:0]   rem_ff, rem_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_load;
   logic               out_free;

   mem_ctl_type        mem_ctl;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  wr_addr;
   logic [VALUE_W-1:0] wr_value;
   logic [IDX_W-1:0]   wr_link;
   logic [VALUE_W-1:0] rd_value;
   logic [IDX_W-1:0]   rd_link;

   logic               req_xfer;
   mode_type           req_mode;
   logic [VALUE_W-1:0] req_value;
   logic               trav_last;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign req_mode   = mode_type'(req_tdata[MODE_W-1:0]);
   assign req_value  = req_tdata[MODE_W +: VALUE_W];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign trav_last  = (rem_ff == IDX_W'(1)) || (rd_link >= END);

   sll_mem #(.CAPACITY(CAPACITY)) u_mem (
      .clock    (clock),
      .ctl      (mem_ctl),
      .rd_addr  (rd_addr),
      .wr_addr  (wr_addr),
      .wr_value (wr_value),
      .wr_link  (wr_link),
      .rd_value (rd_value),
      .rd_link  (rd_link)
   );

   always_comb begin
      state_in      = state_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      rem_in        = rem_ff;
      rsp_load      = 1'b0;
      rsp_value_in  = '0;
      rsp_status_in = STATUS_OK;
      rsp_last_in   = 1'b1;
      mem_ctl       = '0;
      rd_addr       = head_ff[ADDR_W-1:0];
      wr_addr       = count_ff[ADDR_W-1:0];
      wr_value      = value_ff;
      wr_link       = cur_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               value_in  = req_value;
               status_in = STATUS_OK;
               case (req_mode)
                  MODE_CLEAR: begin
                     head_in  = END;
                     tail_in  = END;
                     count_in = '0;
                     state_in = ST_REPLY;
                  end
                  MODE_TRAVERSE: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                        state_in  = ST_REPLY;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = head_ff[ADDR_W-1:0];
                        rem_in        = count_ff;
                        state_in      = ST_TRAVERSE;
                     end
                  end
                  MODE_APPEND: begin
                     if (count_ff >= END) begin
                        status_in = STATUS_FULL;
                        state_in  = ST_REPLY;
                     end else begin
                        cur_in   = END;
                        prev_in  = (tail_ff < END && count_ff != '0) ? tail_ff : END;
                        state_in = ST_LINK_NEW;
                     end
                  end
                  MODE_INSERT: begin
                     if (count_ff >= END) begin
                        status_in = STATUS_FULL;
                        state_in  = ST_REPLY;
                     end else begin
                        prev_in = END;
                        if (head_ff >= END || count_ff == '0) begin
                           cur_in   = END;
                           state_in = ST_LINK_NEW;
                        end else begin
                           cur_in        = head_ff;
                           mem_ctl.rd_en = 1'b1;
                           rd_addr       = head_ff[ADDR_W-1:0];
                           state_in      = ST_INSERT;
                        end
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_INSERT: begin
            // read data belongs to cur_ff
            if ($signed(rd_value) > $signed(value_ff)) begin
               state_in = ST_LINK_NEW;
            end else begin
               prev_in = cur_ff;
               if (rd_link >= END) begin
                  cur_in   = END;
                  state_in = ST_LINK_NEW;
               end else begin
                  cur_in        = rd_link;
                  mem_ctl.rd_en = 1'b1;
                  rd_addr       = rd_link[ADDR_W-1:0];
               end
            end
         end
         ST_LINK_NEW: begin
            mem_ctl.value_we = 1'b1;
            mem_ctl.link_we  = 1'b1;
            wr_addr          = count_ff[ADDR_W-1:0];
            wr_value         = value_ff;
            wr_link          = cur_ff;
            state_in         = ST_LINK_PREV;
         end
         ST_LINK_PREV: begin
            if (prev_ff >= END) begin
               head_in = count_ff;
            end else begin
               mem_ctl.link_we = 1'b1;
               wr_addr         = prev_ff[ADDR_W-1:0];
               wr_link         = count_ff;
            end
            if (cur_ff == END) begin
               tail_in = count_ff;
            end
            count_in = count_ff + IDX_W'(1);
            state_in = ST_REPLY;
         end
         ST_TRAVERSE: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_value_in  = rd_value;
               rsp_status_in = STATUS_OK;
               rsp_last_in   = trav_last;
               if (trav_last) begin
                  state_in = ST_IDLE;
               end else begin
                  mem_ctl.rd_en = 1'b1;
                  rd_addr       = rd_link[ADDR_W-1:0];
                  rem_in        = rem_ff - IDX_W'(1);
               end
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = status_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= END;
         tail_ff      <= END;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      status_ff <= status_in;
      cur_ff    <= cur_in;
      prev_ff   <= prev_in;
      rem_ff    <= rem_in;
      if (rsp_load) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - VALUE_W - STATUS_W)'(0), rsp_status_ff, rsp_value_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= END)
      else $error("entry count above capacity");

   a_head_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) == (head_ff >= END))
      else $error("head pointer disagrees with entry count");

   a_trav_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TRAVERSE) |-> (rem_ff != '0))
      else $error("traverse running with nothing left");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_mode == MODE_CLEAR) |=> (count_ff == '0 && tail_ff == END))
      else $error("clear did not empty the list");

endmodule

[sv/sll_mem.sv]
// Value and link stores: one write port, one registered read port.
module sll_mem import sll_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                               clock,
   input  mem_ctl_type                        ctl,
   input  logic [$clog2(CAPACITY)-1:0]        rd_addr,
   input  logic [$clog2(CAPACITY)-1:0]        wr_addr,
   input  logic [VALUE_W-1:0]                 wr_value,
   input  logic [$clog2(CAPACITY+1)-1:0]      wr_link,
   output logic [VALUE_W-1:0]                 rd_value,
   output logic [$clog2(CAPACITY+1)-1:0]      rd_link
);

   localparam int IDX_W = $clog2(CAPACITY + 1);

   logic [VALUE_W-1:0] value_mem [CAPACITY];
   logic [IDX_W-1:0]   link_mem  [CAPACITY];
   logic [VALUE_W-1:0] rd_value_ff;
   logic [IDX_W-1:0]   rd_link_ff;

   always_ff @(posedge clock) begin
      if (ctl.value_we) begin
         value_mem[wr_addr] <= wr_value;
      end
      if (ctl.link_we) begin
         link_mem[wr_addr] <= wr_link;
      end
      if (ctl.rd_en) begin
         rd_value_ff <= value_mem[rd_addr];
         rd_link_ff  <= link_mem[rd_addr];
      end
   end

   assign rd_value = rd_value_ff;
   assign rd_link  = rd_link_ff;

endmodule
